[rtl/core/interval_task_scheduler_macros.svh]
// ----------------------------------------------------------------------------
// Interval task scheduler assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TASK_SCHEDULER_MACROS_SVH
`define INTERVAL_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication.
`define ITS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define ITS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[rtl/core/its_pkg.sv]
// ----------------------------------------------------------------------------
// its_pkg
// Sizes, command codes and word types of the interval task scheduler.
// ----------------------------------------------------------------------------
package its_pkg;

    localparam int unsigned NUM_SLOTS = 16;
    localparam int unsigned SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int unsigned CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned TIME_W    = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD          = 3'd0,
        CMD_TRIGGER      = 3'd1,
        CMD_SET_ENABLE   = 3'd2,
        CMD_SET_INTERVAL = 3'd3,
        CMD_RUN          = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  slot_index;
        logic [TIME_W-1:0] interval_ms;
        logic              run_now;
        logic              enable_value;
        logic              has_action;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] result_slot;
        logic             fired;
        logic             last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec_op;
        logic scan_en;
        logic flush;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic is_run;
        logic out_free;
        logic scan_done;
        logic scan_stall;
    } sts_t;

endpackage

[rtl/core/its_req_if.sv]
// ----------------------------------------------------------------------------
// its_req_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface its_req_if;

    logic          valid;
    logic          ready;
    its_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[rtl/core/its_rsp_if.sv]
// ----------------------------------------------------------------------------
// its_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
interface its_rsp_if;

    logic          valid;
    logic          ready;
    its_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

[rtl/core/its_ram.sv]
// ----------------------------------------------------------------------------
// its_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module its_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/its_ctrl.sv]
// ----------------------------------------------------------------------------
// its_ctrl
// Sequencer: take a command word, run it or scan the table, emit the result.
// ----------------------------------------------------------------------------
`include "interval_task_scheduler_macros.svh"

module its_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  its_pkg::sts_t sts,
    output its_pkg::ctl_t ctl
);

    import its_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EXEC  = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.is_run)
                begin
                    state_next = ST_SCAN;
                end
                else if (sts.out_free)
                begin
                    ctl.exec_op = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    ctl.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ITS_ASSERT_NEXT(a_load_to_exec, ctl.load, state_reg == ST_EXEC)
    `ITS_ASSERT_NEXT(a_scan_to_flush, state_reg == ST_SCAN && sts.scan_done, state_reg == ST_FLUSH)
    `ITS_ASSERT_SAME(a_emit_when_free, ctl.exec_op || ctl.flush, sts.out_free)

endmodule

[rtl/core/its_dp.sv]
// ----------------------------------------------------------------------------
// its_dp
// Slot table, period and last-run RAMs, scan pipeline and result register.
// ----------------------------------------------------------------------------
`include "interval_task_scheduler_macros.svh"

module its_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  its_pkg::req_t in_data,
    output logic          rsp_valid,
    output its_pkg::rsp_t rsp_data,
    input  logic          rsp_ready,
    input  its_pkg::ctl_t ctl,
    output its_pkg::sts_t sts
);

    import its_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(NUM_SLOTS);
    localparam logic [IDX_W:0]   SLOT_LIM  = (IDX_W + 1)'(NUM_SLOTS);

    req_t               item_reg;
    req_t               item_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;
    logic [NUM_SLOTS-1:0] enabled_reg, enabled_next;
    logic [NUM_SLOTS-1:0] forced_reg, forced_next;
    logic [NUM_SLOTS-1:0] action_reg, action_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic               chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0]  chk_slot_reg, chk_slot_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [SLOT_W-1:0]  pend_slot_reg, pend_slot_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               per_we, last_we, rd_en;
    logic [SLOT_W-1:0]  per_waddr, last_waddr, rd_addr;
    logic [TIME_W-1:0]  per_wdata, last_wdata, per_rdata, last_rdata;

    logic [SLOT_W-1:0]  slot_idx;
    logic [SLOT_W-1:0]  free_slot;
    logic               idx_ok;
    logic [TIME_W-1:0]  elapsed;
    logic               due;
    logic               out_free;
    logic               scan_stall;
    logic               adv;
    logic               issue;
    logic               out_load;
    rsp_t               out_word;

    its_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (per_waddr),
        .wdata (per_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (per_rdata)
    );

    its_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_last_ram (
        .clk   (clk),
        .we    (last_we),
        .waddr (last_waddr),
        .wdata (last_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (last_rdata)
    );

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    assign slot_idx   = item_reg.slot_index[SLOT_W-1:0];
    assign idx_ok     = ({1'b0, item_reg.slot_index} < SLOT_LIM) && used_reg[slot_idx];
    assign elapsed    = item_reg.now_ms - last_rdata;
    assign due        = chk_valid_reg && used_reg[chk_slot_reg] && enabled_reg[chk_slot_reg]
                        && action_reg[chk_slot_reg]
                        && (forced_reg[chk_slot_reg] || (elapsed >= per_rdata));
    assign out_free   = !out_valid_reg || rsp_ready;
    // a due slot pushes the held one out; wait when the result register is busy
    assign scan_stall = due && pend_valid_reg && !out_free;
    assign adv        = ctl.scan_en && !scan_stall;
    assign issue      = adv && (scan_ptr_reg < FULL_CNT);
    assign rd_en      = issue;
    assign rd_addr    = scan_ptr_reg[SLOT_W-1:0];

    always_comb
    begin
        item_next       = ctl.load ? in_data : item_reg;
        used_next       = used_reg;
        enabled_next    = enabled_reg;
        forced_next     = forced_reg;
        action_next     = action_reg;
        count_next      = count_reg;
        scan_ptr_next   = scan_ptr_reg;
        chk_valid_next  = chk_valid_reg;
        chk_slot_next   = chk_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        per_we          = 1'b0;
        per_waddr       = slot_idx;
        per_wdata       = item_reg.interval_ms;
        last_we         = 1'b0;
        last_waddr      = chk_slot_reg;
        last_wdata      = item_reg.now_ms;
        out_load        = 1'b0;
        out_word        = '0;

        if (ctl.load)
        begin
            scan_ptr_next   = '0;
            chk_valid_next  = 1'b0;
            pend_valid_next = 1'b0;
        end

        if (ctl.exec_op)
        begin
            out_load      = 1'b1;
            out_word.last = 1'b1;
            case (item_reg.cmd)
                CMD_ADD:
                begin
                    if (count_reg < FULL_CNT)
                    begin
                        used_next[free_slot]    = 1'b1;
                        enabled_next[free_slot] = 1'b1;
                        forced_next[free_slot]  = item_reg.run_now;
                        action_next[free_slot]  = item_reg.has_action;
                        per_we                  = 1'b1;
                        per_waddr               = free_slot;
                        last_we                 = 1'b1;
                        last_waddr              = free_slot;
                        last_wdata              = item_reg.run_now ? '0 : item_reg.now_ms;
                        count_next              = count_reg + CNT_W'(1);
                        out_word.ok             = 1'b1;
                        out_word.result_slot    = IDX_W'(free_slot);
                    end
                end
                CMD_TRIGGER, CMD_SET_ENABLE, CMD_SET_INTERVAL:
                begin
                    out_word.ok          = idx_ok;
                    out_word.result_slot = item_reg.slot_index;
                    if (idx_ok)
                    begin
                        if (item_reg.cmd == CMD_TRIGGER)
                        begin
                            forced_next[slot_idx] = 1'b1;
                        end
                        else if (item_reg.cmd == CMD_SET_ENABLE)
                        begin
                            enabled_next[slot_idx] = item_reg.enable_value;
                        end
                        else
                        begin
                            per_we = 1'b1;
                        end
                    end
                end
                default:
                begin
                    out_word.ok = 1'b0;
                end
            endcase
        end

        if (adv)
        begin
            if (issue)
            begin
                scan_ptr_next = scan_ptr_reg + CNT_W'(1);
                chk_slot_next = scan_ptr_reg[SLOT_W-1:0];
            end
            chk_valid_next = issue;
            if (due)
            begin
                last_we                   = 1'b1;
                forced_next[chk_slot_reg] = 1'b0;
                pend_valid_next           = 1'b1;
                pend_slot_next            = chk_slot_reg;
                if (pend_valid_reg)
                begin
                    out_load             = 1'b1;
                    out_word.ok          = 1'b1;
                    out_word.result_slot = IDX_W'(pend_slot_reg);
                    out_word.fired       = 1'b1;
                end
            end
        end

        if (ctl.flush)
        begin
            out_load        = 1'b1;
            out_word.ok     = 1'b1;
            out_word.last   = 1'b1;
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                out_word.fired       = 1'b1;
                out_word.result_slot = IDX_W'(pend_slot_reg);
            end
        end

        out_valid_next = out_load || (out_valid_reg && !rsp_ready);
        out_next       = out_load ? out_word : out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg       <= '0;
            enabled_reg    <= '0;
            forced_reg     <= '0;
            action_reg     <= '0;
            count_reg      <= '0;
            scan_ptr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_reg       <= used_next;
            enabled_reg    <= enabled_next;
            forced_reg     <= forced_next;
            action_reg     <= action_next;
            count_reg      <= count_next;
            scan_ptr_reg   <= scan_ptr_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        chk_slot_reg  <= chk_slot_next;
        pend_slot_reg <= pend_slot_next;
        out_reg       <= out_next;
    end

    assign rsp_valid      = out_valid_reg;
    assign rsp_data       = out_reg;
    assign sts.is_run     = (item_reg.cmd == CMD_RUN);
    assign sts.out_free   = out_free;
    assign sts.scan_done  = (scan_ptr_reg == FULL_CNT) && !chk_valid_reg;
    assign sts.scan_stall = scan_stall;

    `ITS_ASSERT_SAME(a_count_matches, 1'b1, count_reg == CNT_W'($countones(used_reg)))
    `ITS_ASSERT_SAME(a_fired_is_ok, out_valid_reg && out_reg.fired, out_reg.ok)
    `ITS_ASSERT_SAME(a_load_when_free, out_load, out_free)

endmodule

[rtl/core/interval_task_scheduler.sv]
// Add, trigger, set enable, set interval: the word is registered on accept;
//   the exec state loads its result word once the result register is free.
// Run tick: one slot per cycle through the period/last-run RAM read port,
//   except while a due slot and a held slot wait on a busy result register.
// Throughput: one command at a time; a result may wait while the next is taken.
// Reset (rst_n low, async): empty table, no pending result; RAMs are not cleared.
// ----------------------------------------------------------------------------
// interval_task_scheduler
// Periodic task slot table with add, trigger, enable, interval and run tick.
// ----------------------------------------------------------------------------
module interval_task_scheduler (
    input  logic clk,
    input  logic rst_n,
    its_req_if.sink   req,
    its_rsp_if.source rsp
);

    import its_pkg::*;

    // Command and status between the sequencer and the datapath.
    ctl_t ctl;
    sts_t sts;

    // The sequencer owns the command handshake: a word is taken only in its
    // idle state, which the result register does not block, so a finished
    // result can sit in the output while the next command comes in.
    its_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath holds the flag bits in flops and the period and last-run
    // times in two RAMs. A run tick streams slot addresses into the RAMs,
    // checks each returned slot in the next cycle, and keeps the latest due
    // slot in a hold register: the next due slot pushes it out with last=0,
    // and the end of the scan flushes it with last=1, or emits a not-fired
    // word when nothing was due.
    its_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (req.data),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

[bench/interval_task_scheduler_tb.sv]
// ----------------------------------------------------------------------------
// interval_task_scheduler_tb
// Self-checking bench for the interval task scheduler.
// A directed table walks reset behavior, table fill, rejected slot commands,
// wrap-around time and unknown commands. Random command words follow. Both
// channels idle in bursts, and the result side holds off long enough to
// back up the command side. Each result word is compared field by field
// against a behavioral copy of the slot table.
// ----------------------------------------------------------------------------
module interval_task_scheduler_tb;

    import its_pkg::*;

    // Command codes the block does not define; it must reject them.
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int unsigned IDX_MAX     = (1 << IDX_W) - 1;
    localparam int          DIR_ROWS    = 23;
    localparam int          RAND_ITEMS  = 175;
    localparam int          TAIL_QUIET  = 40;   // last random words run with no idling
    localparam int          HOLD_AT     = 60;   // random word that starts the long hold-off
    localparam int          PAUSE_AT    = 120;  // random word before which the sender drains
    localparam int          HOLD_CYCLES = 120;
    // A run tick scans every slot and may emit up to 16 result words that may
    // each wait out a random stall; the long hold-off runs HOLD_CYCLES. Allow
    // several times the worst case.
    localparam int          STALL_LIMIT = 2000;
    localparam int          DRAIN_WAIT  = NUM_SLOTS + 10;

    logic clk;
    logic rst_n;

    its_req_if req_ch ();
    its_rsp_if rsp_ch ();

    interval_task_scheduler u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Slot table copy, updated on every accepted command word
    // ------------------------------------------------------------------
    bit                slot_used   [NUM_SLOTS];
    bit                slot_enabled[NUM_SLOTS];
    bit                slot_forced [NUM_SLOTS];
    bit                slot_action [NUM_SLOTS];
    logic [TIME_W-1:0] slot_period [NUM_SLOTS];
    logic [TIME_W-1:0] slot_last   [NUM_SLOTS];
    int                slots_taken;

    rsp_t new_results[$];     // result words of the command just applied
    rsp_t result_backlog[$];  // result words the block still owes, oldest first

    int   fail_count;
    bit   steady_tail;        // no idling on either side
    bit   send_idle_mode;
    int   hold_asks;          // bumped by the sender, served by the result side

    // Directed rows may carry a hand-typed result; it travels with the word.
    bit               row_typed;
    bit               typed_ok;
    logic [IDX_W-1:0] typed_slot;

    logic [TIME_W-1:0] now_cursor;

    function automatic rsp_t make_rsp(bit ok, logic [IDX_W-1:0] slot, bit fired, bit last);
        rsp_t r;
        r.ok          = ok;
        r.result_slot = slot;
        r.fired       = fired;
        r.last        = last;
        return r;
    endfunction

    // Apply one command to the slot table and collect the words it causes.
    task automatic apply_command(input req_t w);
        bit                found;
        bit                slot_ok;
        bit [NUM_SLOTS-1:0] due_mask;
        int                due_total;
        int                emitted;
        logic [TIME_W-1:0] elapsed;
        new_results.delete();
        case (w.cmd)
            CMD_ADD:
            begin
                found = 1'b0;
                if (slots_taken < NUM_SLOTS)
                begin
                    for (int i = 0; i < NUM_SLOTS && !found; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            found           = 1'b1;
                            slot_used[i]    = 1'b1;
                            slot_enabled[i] = 1'b1;
                            slot_forced[i]  = w.run_now;
                            slot_action[i]  = w.has_action;
                            slot_period[i]  = w.interval_ms;
                            slot_last[i]    = w.run_now ? '0 : w.now_ms;
                            slots_taken++;
                            new_results.push_back(make_rsp(1'b1, IDX_W'(i), 1'b0, 1'b1));
                        end
                    end
                end
                if (!found)
                    new_results.push_back(make_rsp(1'b0, '0, 1'b0, 1'b1));
            end
            CMD_TRIGGER, CMD_SET_ENABLE, CMD_SET_INTERVAL:
            begin
                slot_ok = 1'b0;
                if (w.slot_index < NUM_SLOTS)
                    slot_ok = slot_used[w.slot_index];
                if (slot_ok)
                begin
                    if (w.cmd == CMD_TRIGGER)
                        slot_forced[w.slot_index] = 1'b1;
                    else if (w.cmd == CMD_SET_ENABLE)
                        slot_enabled[w.slot_index] = w.enable_value;
                    else
                        slot_period[w.slot_index] = w.interval_ms;
                end
                new_results.push_back(make_rsp(slot_ok, w.slot_index, 1'b0, 1'b1));
            end
            CMD_RUN:
            begin
                // Mark due slots first so the final word can carry last.
                due_mask  = '0;
                due_total = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    elapsed = w.now_ms - slot_last[i];
                    if (slot_used[i] && slot_enabled[i] && slot_action[i] &&
                        (slot_forced[i] || elapsed >= slot_period[i]))
                    begin
                        due_mask[i] = 1'b1;
                        due_total++;
                    end
                end
                emitted = 0;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (due_mask[i])
                    begin
                        slot_last[i]   = w.now_ms;
                        slot_forced[i] = 1'b0;
                        emitted++;
                        new_results.push_back(make_rsp(1'b1, IDX_W'(i), 1'b1,
                                                       emitted == due_total));
                    end
                end
                if (due_total == 0)
                    new_results.push_back(make_rsp(1'b1, '0, 1'b0, 1'b1));
            end
            default:
                new_results.push_back(make_rsp(1'b0, '0, 1'b0, 1'b1));
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: result field %s mismatch: expected %0d, actual %0d",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Handshake monitor: check result words, apply command words, and
    // watch for a stuck block.
    // ------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin : handshake_monitor
        rsp_t want;
        if (rst_n)
        begin
            // Results first: a word leaving now always belongs to an
            // earlier command.
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (result_backlog.size() == 0)
                begin
                    $display("%0t: result word with nothing outstanding: ok=%0d slot=%0d fired=%0d last=%0d",
                             $time, rsp_ch.data.ok, rsp_ch.data.result_slot,
                             rsp_ch.data.fired, rsp_ch.data.last);
                    fail_count++;
                end
                else
                begin
                    want = result_backlog.pop_front();
                    check_field("ok",          want.ok,          rsp_ch.data.ok);
                    check_field("result_slot", want.result_slot, rsp_ch.data.result_slot);
                    check_field("fired",       want.fired,       rsp_ch.data.fired);
                    check_field("last",        want.last,        rsp_ch.data.last);
                end
            end

            if (req_ch.valid && req_ch.ready)
            begin
                apply_command(req_ch.data);
                // A typed row replaces the computed word; the table is still updated.
                if (row_typed)
                    result_backlog.push_back(make_rsp(typed_ok, typed_slot, 1'b0, 1'b1));
                else
                    foreach (new_results[k])
                        result_backlog.push_back(new_results[k]);
            end

            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT)
                begin
                    $display("%0t: no handshake for %0d cycles, %0d result words outstanding",
                             $time, idle_cycles, result_backlog.size());
                    $display("interval_task_scheduler_tb: FAIL");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall bursts, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int  hold_served;
        int  tick;
        bit  stall_mode;
        hold_served = 0;
        tick        = 0;
        stall_mode  = 1'b1;
        rsp_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            tick++;
            // Alternate stretches with and without stalls.
            if (tick % 32 == 0)
                stall_mode = ($urandom_range(0, 2) != 0);
            if (hold_asks != hold_served)
            begin
                // Hold off long enough for the block to back up its input.
                hold_served = hold_asks;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (!steady_tail && stall_mode && $urandom_range(0, 5) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------

    // Offer one word and hold it until the block takes it. Returns at the
    // accepting edge with valid still high.
    task automatic send_word(input req_t w, input bit typed, input bit t_ok,
                             input logic [IDX_W-1:0] t_slot);
        req_ch.valid <= 1'b1;
        req_ch.data  <= w;
        row_typed    <= typed;
        typed_ok     <= t_ok;
        typed_slot   <= t_slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        if (!steady_tail && send_idle_mode && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Drop valid and hold until every outstanding result word has arrived.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (result_backlog.size() != 0)
            @(posedge clk);
    endtask

    function automatic req_t random_command();
        req_t w;
        int   pick;
        // Unused fields carry noise so every bit toggles.
        w.cmd          = CMD_RUN;
        w.slot_index   = IDX_W'($urandom);
        w.interval_ms  = $urandom;
        w.run_now      = 1'($urandom);
        w.enable_value = 1'($urandom);
        w.has_action   = 1'($urandom);
        w.now_ms       = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // Advance time in small steps, with an occasional jump that may wrap.
            w.cmd = CMD_RUN;
            if ($urandom_range(0, 9) == 0)
                now_cursor = $urandom;
            else
                now_cursor = now_cursor + $urandom_range(0, 150);
            w.now_ms = now_cursor;
        end
        else if (pick < 55)
        begin
            w.cmd        = CMD_TRIGGER;
            w.slot_index = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
        end
        else if (pick < 67)
        begin
            w.cmd          = CMD_SET_ENABLE;
            w.slot_index   = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
            w.enable_value = ($urandom_range(0, 3) != 0);
        end
        else if (pick < 82)
        begin
            w.cmd         = CMD_SET_INTERVAL;
            w.slot_index  = IDX_W'($urandom_range(0, NUM_SLOTS - 1));
            w.interval_ms = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 300);
        end
        else if (pick < 90)
        begin
            w.cmd    = CMD_ADD;
            w.now_ms = now_cursor;
        end
        else if (pick < 95)
        begin
            // Slot command aimed past the end of the table.
            w.cmd        = CMD_W'($urandom_range(CMD_TRIGGER, CMD_SET_INTERVAL));
            w.slot_index = IDX_W'($urandom_range(NUM_SLOTS, IDX_MAX));
        end
        else
            w.cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
        return w;
    endfunction

    // Directed stimulus table. Rows marked typed carry the single result
    // word by hand; the others go through the slot table copy.
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] interval;
        bit                run_now;
        bit                enable;
        bit                action;
        logic [TIME_W-1:0] now;
        int                reps;
        bit                typed;
        bit                ok;
        logic [IDX_W-1:0]  slot;
    } dir_row_t;

    dir_row_t dir_rows[DIR_ROWS];

    function automatic dir_row_t mk_row(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                                        logic [TIME_W-1:0] interval, bit run_now,
                                        bit enable, bit action, logic [TIME_W-1:0] now,
                                        int reps, bit typed, bit ok,
                                        logic [IDX_W-1:0] slot);
        dir_row_t r;
        r.cmd      = cmd;
        r.idx      = idx;
        r.interval = interval;
        r.run_now  = run_now;
        r.enable   = enable;
        r.action   = action;
        r.now      = now;
        r.reps     = reps;
        r.typed    = typed;
        r.ok       = ok;
        r.slot     = slot;
        return r;
    endfunction

    initial
    begin : command_source
        req_t w;
        // Empty table: a tick finds nothing, slot commands are refused.
        dir_rows[0]  = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'd0,        1, 1, 1, 6'd0);
        dir_rows[1]  = mk_row(CMD_TRIGGER,      6'd0,  32'd0,        0, 0, 0, 32'd0,        1, 1, 0, 6'd0);
        dir_rows[2]  = mk_row(CMD_SET_ENABLE,   6'd63, 32'd0,        0, 1, 0, 32'd0,        1, 1, 0, 6'd63);
        dir_rows[3]  = mk_row(CMD_SET_INTERVAL, 6'd15, 32'hFFFFFFFF, 0, 0, 0, 32'd0,        1, 1, 0, 6'd15);
        // Unknown codes, all fields low and all fields high.
        dir_rows[4]  = mk_row(CMD_RSVD_7,       6'd0,  32'd0,        0, 0, 0, 32'd0,        1, 1, 0, 6'd0);
        dir_rows[5]  = mk_row(CMD_RSVD_5,       6'd63, 32'hFFFFFFFF, 1, 1, 1, 32'hFFFFFFFF, 1, 1, 0, 6'd0);
        // Zero period, forced first run with full period, slot without an action.
        dir_rows[6]  = mk_row(CMD_ADD,          6'd0,  32'd0,        0, 0, 1, 32'd100,      1, 1, 1, 6'd0);
        dir_rows[7]  = mk_row(CMD_ADD,          6'd0,  32'hFFFFFFFF, 1, 0, 1, 32'hFFFFFFFF, 1, 1, 1, 6'd1);
        dir_rows[8]  = mk_row(CMD_ADD,          6'd0,  32'd10,       0, 0, 0, 32'd0,        1, 1, 1, 6'd2);
        dir_rows[9]  = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'd100,      1, 0, 0, 6'd0);
        // Trigger on a slot with no action must not fire it.
        dir_rows[10] = mk_row(CMD_TRIGGER,      6'd2,  32'd0,        0, 0, 0, 32'd0,        1, 1, 1, 6'd2);
        dir_rows[11] = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'd100,      1, 0, 0, 6'd0);
        dir_rows[12] = mk_row(CMD_SET_ENABLE,   6'd0,  32'd0,        0, 0, 0, 32'd0,        1, 1, 1, 6'd0);
        dir_rows[13] = mk_row(CMD_SET_INTERVAL, 6'd1,  32'd0,        0, 0, 0, 32'd0,        1, 1, 1, 6'd1);
        // First index past the table.
        dir_rows[14] = mk_row(CMD_TRIGGER,      6'd16, 32'd0,        0, 0, 0, 32'd0,        1, 1, 0, 6'd16);
        dir_rows[15] = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'h7FFFFFFF, 1, 0, 0, 6'd0);
        dir_rows[16] = mk_row(CMD_SET_ENABLE,   6'd0,  32'd0,        0, 1, 0, 32'd0,        1, 1, 1, 6'd0);
        // Fill the rest of the table just before the time wraps, then overflow it.
        dir_rows[17] = mk_row(CMD_ADD,          6'd0,  32'h20,       0, 0, 1, 32'hFFFFFFF0, 13, 0, 0, 6'd0);
        dir_rows[18] = mk_row(CMD_ADD,          6'd0,  32'd1,        1, 1, 1, 32'd0,        1, 1, 0, 6'd0);
        // Tick after the wrap: the filled slots are due on a wrapped difference.
        dir_rows[19] = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'h10,       1, 0, 0, 6'd0);
        dir_rows[20] = mk_row(CMD_RUN,          6'd0,  32'd0,        0, 0, 0, 32'h11,       1, 0, 0, 6'd0);
        dir_rows[21] = mk_row(CMD_RSVD_6,       6'd5,  32'd7,        0, 1, 0, 32'd3,        1, 1, 0, 6'd0);
        dir_rows[22] = mk_row(CMD_SET_INTERVAL, 6'd2,  32'd5,        0, 0, 0, 32'd0,        1, 1, 1, 6'd2);

        // Clear the slot table copy and drive every input to a known value.
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_used[i]    = 1'b0;
            slot_enabled[i] = 1'b0;
            slot_forced[i]  = 1'b0;
            slot_action[i]  = 1'b0;
            slot_period[i]  = '0;
            slot_last[i]    = '0;
        end
        slots_taken    = 0;
        fail_count     = 0;
        idle_cycles    = 0;
        steady_tail    = 1'b0;
        send_idle_mode = 1'b1;
        hold_asks      = 0;
        row_typed      = 1'b0;
        typed_ok       = 1'b0;
        typed_slot     = '0;
        now_cursor     = 32'h12;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;

        // Hold reset low once, then release it.
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
            begin
                w.cmd          = dir_rows[r].cmd;
                w.slot_index   = dir_rows[r].idx;
                w.interval_ms  = dir_rows[r].interval;
                w.run_now      = dir_rows[r].run_now;
                w.enable_value = dir_rows[r].enable;
                w.has_action   = dir_rows[r].action;
                w.now_ms       = dir_rows[r].now;
                send_word(w, dir_rows[r].typed, dir_rows[r].ok, dir_rows[r].slot);
                sender_gap();
            end
        end
        drain_results();

        // Random part.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 16 == 0)
                send_idle_mode = ($urandom_range(0, 2) != 0);
            // Ask the result side to stall for a long stretch while words keep coming.
            if (n == HOLD_AT)
                hold_asks <= hold_asks + 1;
            // Let everything settle before carrying on.
            if (n == PAUSE_AT)
                drain_results();
            if (n == RAND_ITEMS - TAIL_QUIET)
                steady_tail = 1'b1;
            send_word(random_command(), 1'b0, 1'b0, '0);
            sender_gap();
        end

        drain_results();
        // Give a late stray word time to show up.
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("interval_task_scheduler_tb: PASS");
        else
            $display("interval_task_scheduler_tb: FAIL");
        $finish;
    end

endmodule

[interval_task_scheduler.f]
+incdir+rtl/core
rtl/core/its_pkg.sv
rtl/core/its_req_if.sv
rtl/core/its_rsp_if.sv
rtl/core/its_ram.sv
rtl/core/its_ctrl.sv
rtl/core/its_dp.sv
rtl/core/interval_task_scheduler.sv
bench/interval_task_scheduler_tb.sv
